// File: rtl/imbs_pkg.sv
`timescale 1ns / 1ps
package imbs_pkg;

  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int PC_W    = 5;
  localparam int CNT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_ACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_NAK = 3'd4;

  localparam logic [1:0] SDA_LO  = 2'd0;
  localparam logic [1:0] SDA_HI  = 2'd1;
  localparam logic [1:0] SDA_BIT = 2'd2;
  localparam logic [1:0] SDA_ACK = 2'd3;

  localparam logic [PC_W-1:0] PC_START     = 5'd0;
  localparam logic [PC_W-1:0] PC_STOP      = 5'd4;
  localparam logic [PC_W-1:0] PC_WRITE     = 5'd8;
  localparam logic [PC_W-1:0] PC_WRITE_ACK = 5'd11;
  localparam logic [PC_W-1:0] PC_READ      = 5'd14;
  localparam logic [PC_W-1:0] PC_READ_BIT  = 5'd15;
  localparam logic [PC_W-1:0] PC_READ_ACK  = 5'd17;

  localparam logic [CNT_W-1:0] BIT_LOOPS = 3'd7;

  typedef struct packed {
    logic            scl;
    logic [1:0]      sda_sel;
    logic            drive;
    logic            last;
    logic            ack;
    logic            rd;
    logic            rot;
    logic            loop;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic logic [PC_W-1:0] imbs_entry(input logic [CMD_W-1:0] cmd);
    logic [PC_W-1:0] pc;
    pc = PC_START;
    unique case (cmd)
      CMD_START:    pc = PC_START;
      CMD_STOP:     pc = PC_STOP;
      CMD_WRITE:    pc = PC_WRITE;
      CMD_READ_ACK,
      CMD_READ_NAK: pc = PC_READ;
      default:      pc = PC_START;
    endcase
    return pc;
  endfunction

  function automatic ucode_t imbs_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    //          scl  sda      drv   last  ack   rd    rot   loop  target
    w = '{1'b0, SDA_LO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
    unique case (pc)
      5'd0:  w = '{1'b0, SDA_HI,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd1:  w = '{1'b1, SDA_HI,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd2:  w = '{1'b1, SDA_LO,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd3:  w = '{1'b0, SDA_LO,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd4:  w = '{1'b0, SDA_LO,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd5:  w = '{1'b1, SDA_LO,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd6:  w = '{1'b1, SDA_HI,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd7:  w = '{1'b0, SDA_HI,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd8:  w = '{1'b0, SDA_BIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd9:  w = '{1'b1, SDA_BIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd10: w = '{1'b0, SDA_BIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, PC_WRITE};
      5'd11: w = '{1'b0, SDA_LO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd12: w = '{1'b1, SDA_LO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd13: w = '{1'b0, SDA_LO,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, PC_START};
      5'd14: w = '{1'b0, SDA_LO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd15: w = '{1'b1, SDA_LO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_START};
      5'd16: w = '{1'b0, SDA_LO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_READ_BIT};
      5'd17: w = '{1'b0, SDA_ACK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd18: w = '{1'b1, SDA_ACK, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
      5'd19: w = '{1'b0, SDA_ACK, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, PC_START};
      default: w = '{1'b0, SDA_LO, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid / in_ready  command, data, slave_byte, slave_ack, add_to_sum, clear_sums
// out      out_valid / out_ready scl, sda_level, sda_drive, rx_byte, ack_received,
//                               sums_match, last
//
// One line phase per cycle from the control table while the output is not stalled, once
// the item has been loaded on acceptance; unused command codes are accepted, load nothing
// and emit nothing.
// A new item is taken once the last phase of the previous one is in the output register.
// Synchronous reset clears both checksums, the sequencer and the output valid flag.
// A stalled output holds the sequencer on its current step.
module i2c_master_byte_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] command,
  input  logic [7:0] data,
  input  logic [7:0] slave_byte,
  input  logic       slave_ack,
  input  logic       add_to_sum,
  input  logic       clear_sums,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl,
  output logic       sda_level,
  output logic       sda_drive,
  output logic [7:0] rx_byte,
  output logic       ack_received,
  output logic       sums_match,
  output logic       last
);
  import imbs_pkg::*;

  logic              busy;
  logic              accept;
  logic              load;
  logic              step;
  logic              cmd_ok;
  logic              is_read;
  ucode_t            word;
  logic [BYTE_W-1:0] shreg;
  logic              sack;
  logic              nack;
  logic              match;
  logic [BYTE_W-1:0] wsum;
  logic [BYTE_W-1:0] rsum;
  logic [BYTE_W-1:0] wsum_next;
  logic [BYTE_W-1:0] rsum_next;
  logic              sda_bit;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign is_read  = command == CMD_READ_ACK || command == CMD_READ_NAK;
  assign cmd_ok   = command <= CMD_READ_NAK;
  assign load     = accept && cmd_ok;
  assign step     = busy && (!out_valid || out_ready);

  imbs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .cmd  (command),
    .step (step),
    .word (word)
  );

  always_comb begin
    wsum_next = clear_sums ? '0 : wsum;
    rsum_next = clear_sums ? '0 : rsum;
    if (add_to_sum && command == CMD_WRITE) wsum_next = wsum_next + data;
    if (add_to_sum && is_read)              rsum_next = rsum_next + slave_byte;
  end

  always_comb begin
    sda_bit = 1'b0;
    case (word.sda_sel)
      SDA_LO:  sda_bit = 1'b0;
      SDA_HI:  sda_bit = 1'b1;
      SDA_BIT: sda_bit = shreg[BYTE_W-1];
      SDA_ACK: sda_bit = nack;
      default: sda_bit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wsum <= '0;
      rsum <= '0;
    end else if (accept) begin
      busy <= cmd_ok;
      wsum <= wsum_next;
      rsum <= rsum_next;
    end else if (step && word.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= is_read ? slave_byte : data;
      sack  <= slave_ack;
      nack  <= command == CMD_READ_NAK;
      match <= wsum_next == rsum_next;
    end else if (step && word.rot) begin
      shreg <= {shreg[BYTE_W-2:0], shreg[BYTE_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      scl          <= word.scl;
      sda_level    <= sda_bit;
      sda_drive    <= word.drive;
      rx_byte      <= word.rd ? shreg : '0;
      ack_received <= word.ack && !sack;
      sums_match   <= match;
      last         <= word.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy |-> last)
    else $error("idle with a phase other than the final one pending");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (ack_received || rx_byte != '0) |-> last)
    else $error("status reported before the final phase");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_drive |-> !sda_level)
    else $error("released line carries a high level");

  assert property (@(posedge clk) disable iff (rst)
    step && word.last |=> !busy && out_valid && last)
    else $error("final phase did not end the command");

endmodule

// File: rtl/imbs_seq.sv
`timescale 1ns / 1ps
module imbs_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [imbs_pkg::CMD_W-1:0] cmd,
  input  logic                       step,
  output imbs_pkg::ucode_t           word
);
  import imbs_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [CNT_W-1:0] cnt;

  assign word = imbs_rom(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_START;
      cnt <= '0;
    end else if (load) begin
      pc  <= imbs_entry(cmd);
      cnt <= BIT_LOOPS;
    end else if (step) begin
      if (word.loop && cnt != '0) begin
        pc  <= word.target;
        cnt <= cnt - 1'b1;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    step && word.loop && cnt != '0 |=> pc == $past(word.target))
    else $error("loop jump missed its target");

  assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == BIT_LOOPS)
    else $error("bit counter not loaded");

  assert property (@(posedge clk) disable iff (rst)
    step && !word.loop |=> cnt == $past(cnt))
    else $error("bit counter moved outside a loop step");

endmodule

// File: tb/i2c_phase_checker.sv
`timescale 1ns / 1ps
module i2c_phase_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] command,
  input  logic [7:0] data,
  input  logic [7:0] slave_byte,
  input  logic       slave_ack,
  input  logic       add_to_sum,
  input  logic       clear_sums,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       scl,
  input  logic       sda_level,
  input  logic       sda_drive,
  input  logic [7:0] rx_byte,
  input  logic       ack_received,
  input  logic       sums_match,
  input  logic       last,
  output int         mismatches,
  output int         pending_phases,
  output int         commands_seen,
  output int         phases_seen,
  output int         equal_sum_phases
);
  import imbs_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       sums_match;
    logic       last;
  } line_phase_t;

  line_phase_t expected_phases[$];
  logic [7:0]  write_sum;
  logic [7:0]  rx_sum;

  initial begin
    mismatches       = 0;
    pending_phases   = 0;
    commands_seen    = 0;
    phases_seen      = 0;
    equal_sum_phases = 0;
    write_sum        = '0;
    rx_sum           = '0;
  end

  task automatic push_phase(input logic s, input logic lvl, input logic drv,
                            input logic [7:0] rd, input logic ack,
                            input logic eq, input logic fin);
    line_phase_t p;
    p.scl          = s;
    p.sda_level    = lvl;
    p.sda_drive    = drv;
    p.rx_byte      = rd;
    p.ack_received = ack;
    p.sums_match   = eq;
    p.last         = fin;
    expected_phases.push_back(p);
  endtask

  task automatic predict_line_phases(input logic [2:0] cmd, input logic [7:0] dat,
                                     input logic [7:0] sbyte, input logic sack,
                                     input logic add, input logic clr);
    logic eq;
    logic nak;
    if (clr) begin
      write_sum = '0;
      rx_sum    = '0;
    end
    if (add && cmd == CMD_WRITE)
      write_sum = write_sum + dat;
    if (add && (cmd == CMD_READ_ACK || cmd == CMD_READ_NAK))
      rx_sum = rx_sum + sbyte;
    eq  = (write_sum == rx_sum);
    nak = (cmd == CMD_READ_NAK);
    case (cmd)
      CMD_START: begin
        push_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, eq, 1'b1);
      end
      CMD_STOP: begin
        push_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0, eq, 1'b1);
      end
      CMD_WRITE: begin
        for (int b = 7; b >= 0; b--) begin
          push_phase(1'b0, dat[b], 1'b1, 8'h00, 1'b0, eq, 1'b0);
          push_phase(1'b1, dat[b], 1'b1, 8'h00, 1'b0, eq, 1'b0);
          push_phase(1'b0, dat[b], 1'b1, 8'h00, 1'b0, eq, 1'b0);
        end
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, !sack, eq, 1'b1);
      end
      CMD_READ_ACK, CMD_READ_NAK: begin
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, eq, 1'b0);
        for (int b = 7; b >= 0; b--) begin
          push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, eq, 1'b0);
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, eq, 1'b0);
        end
        push_phase(1'b0, nak, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b1, nak, 1'b1, 8'h00, 1'b0, eq, 1'b0);
        push_phase(1'b0, nak, 1'b1, sbyte, 1'b0, eq, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: phase %0d %s expected %0h got %0h", $time, phases_seen, name,
               want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    line_phase_t want;
    if (rst) begin
      write_sum = '0;
      rx_sum    = '0;
      expected_phases.delete();
    end else begin
      if (in_valid && in_ready) begin
        commands_seen++;
        predict_line_phases(command, data, slave_byte, slave_ack, add_to_sum, clear_sums);
      end
      if (out_valid && out_ready) begin
        phases_seen++;
        if (sums_match === 1'b1)
          equal_sum_phases++;
        if (expected_phases.size() == 0) begin
          mismatches++;
          $display("%0t: phase %0d expected none got scl=%b sda=%b drive=%b last=%b",
                   $time, phases_seen, scl, sda_level, sda_drive, last);
        end else begin
          want = expected_phases.pop_front();
          check_field("scl", {7'd0, want.scl}, {7'd0, scl});
          check_field("sda_level", {7'd0, want.sda_level}, {7'd0, sda_level});
          check_field("sda_drive", {7'd0, want.sda_drive}, {7'd0, sda_drive});
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_field("ack_received", {7'd0, want.ack_received}, {7'd0, ack_received});
          check_field("sums_match", {7'd0, want.sums_match}, {7'd0, sums_match});
          check_field("last", {7'd0, want.last}, {7'd0, last});
        end
      end
    end
    pending_phases = expected_phases.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import imbs_pkg::*;

  localparam int ITEMS      = 220;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN      = 40;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] command;
  logic [7:0] data;
  logic [7:0] slave_byte;
  logic       slave_ack;
  logic       add_to_sum;
  logic       clear_sums;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl;
  logic       sda_level;
  logic       sda_drive;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       sums_match;
  logic       last;

  int mismatches;
  int pending_phases;
  int commands_seen;
  int phases_seen;
  int equal_sum_phases;
  int items_sent;
  int idle_cycles;
  int ready_hold;
  bit no_idle;
  logic [7:0] summed_writes[$];

  i2c_master_byte_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data         (data),
    .slave_byte   (slave_byte),
    .slave_ack    (slave_ack),
    .add_to_sum   (add_to_sum),
    .clear_sums   (clear_sums),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scl          (scl),
    .sda_level    (sda_level),
    .sda_drive    (sda_drive),
    .rx_byte      (rx_byte),
    .ack_received (ack_received),
    .sums_match   (sums_match),
    .last         (last)
  );

  i2c_phase_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .data             (data),
    .slave_byte       (slave_byte),
    .slave_ack        (slave_ack),
    .add_to_sum       (add_to_sum),
    .clear_sums       (clear_sums),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scl              (scl),
    .sda_level        (sda_level),
    .sda_drive        (sda_drive),
    .rx_byte          (rx_byte),
    .ack_received     (ack_received),
    .sums_match       (sums_match),
    .last             (last),
    .mismatches       (mismatches),
    .pending_phases   (pending_phases),
    .commands_seen    (commands_seen),
    .phases_seen      (phases_seen),
    .equal_sum_phases (equal_sum_phases)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (no_idle || $urandom_range(0, 99) >= 25) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] dat,
                          input logic [7:0] sbyte, input logic sack,
                          input logic add, input logic clr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    data       <= dat;
    slave_byte <= sbyte;
    slave_ack  <= sack;
    add_to_sum <= add;
    clear_sums <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd <= CMD_READ_NAK)
      items_sent++;
  endtask

  task automatic run_transfer();
    logic       is_read;
    logic       add;
    logic [7:0] addr;
    logic [7:0] b;
    int         n;
    is_read = 1'($urandom_range(0, 1));
    n       = $urandom_range(1, 4);
    addr    = 8'($urandom);
    addr[0] = is_read;
    send_cmd(CMD_START, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
             $urandom_range(0, 11) == 0);
    send_cmd(CMD_WRITE, addr, 8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom), 1'b0);
    for (int i = 0; i < n; i++) begin
      add = ($urandom_range(0, 3) != 0);
      if (!is_read) begin
        b = 8'($urandom);
        send_cmd(CMD_WRITE, b, 8'($urandom), $urandom_range(0, 7) == 0, add,
                 $urandom_range(0, 11) == 0);
        if (add)
          summed_writes.push_back(b);
        if (summed_writes.size() > 8)
          void'(summed_writes.pop_front());
      end else begin
        if (add && summed_writes.size() > 0 && $urandom_range(0, 1))
          b = summed_writes.pop_front();
        else
          b = 8'($urandom);
        send_cmd((i == n - 1) ? CMD_READ_NAK : CMD_READ_ACK, 8'($urandom), b,
                 1'($urandom), add, $urandom_range(0, 11) == 0);
      end
    end
    send_cmd(CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
             $urandom_range(0, 11) == 0);
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= CMD_START;
    data       <= 8'h00;
    slave_byte <= 8'h00;
    slave_ack  <= 1'b0;
    add_to_sum <= 1'b0;
    clear_sums <= 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    ready_hold  = 0;
    no_idle     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_cmd(CMD_START,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_WRITE,     8'hFF, 8'h00, 1'b0, 1'b1, 1'b1);
    send_cmd(CMD_WRITE,     8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_WRITE,     8'hA5, 8'h5A, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_READ_ACK,  8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_READ_NAK,  8'hFF, 8'h00, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_STOP,      8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_START,     8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_WRITE,     8'h02, 8'h00, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_READ_ACK,  8'h00, 8'h01, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_READ_NAK,  8'h00, 8'h02, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_SPARE_LO,  8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_cmd(CMD_WRITE,     8'hFE, 8'h01, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_SPARE_MID, 8'h01, 8'hFE, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_READ_ACK,  8'h00, 8'hFD, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_SPARE_HI,  8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    send_cmd(CMD_READ_NAK,  8'hAA, 8'h55, 1'b1, 1'b0, 1'b0);
    send_cmd(CMD_WRITE,     8'h5A, 8'hA5, 1'b1, 1'b0, 1'b1);
    send_cmd(CMD_STOP,      8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    send_cmd(CMD_START,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(CMD_WRITE,     8'h80, 8'h7F, 1'b0, 1'b1, 1'b0);
    send_cmd(CMD_READ_NAK,  8'h7F, 8'h80, 1'b1, 1'b1, 1'b0);
    send_cmd(CMD_STOP,      8'h00, 8'h00, 1'b0, 1'b0, 1'b0);

    while (items_sent < ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 8)
        run_transfer();
      else
        repeat ($urandom_range(1, 3))
          send_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1'($urandom),
                   1'($urandom), $urandom_range(0, 5) == 0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_phases != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d commands through start, stop, write and read sequences", commands_seen);
    $display("and compared %0d line phases, %0d of them with equal checksums.",
             phases_seen, equal_sum_phases);
    if (mismatches == 0 && pending_phases == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0t: %0d mismatches, %0d phases never seen", $time, mismatches,
               pending_phases);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/imbs_pkg.sv
rtl/imbs_seq.sv
rtl/i2c_master_byte_sequencer.sv
tb/i2c_phase_checker.sv
tb/tb.sv
